@@ hdl/tkns_pkg.sv @@
// Shared types, constants and helpers for the top-k nearest neighbor selector.
// No dependencies; imported by the controller, the datapath and the top level.
package tkns_pkg;

    localparam int K_MAX      = 16;
    localparam int INDEX_BITS = 16;
    localparam int LABEL_BITS = 8;
    localparam int DIST_BITS  = 32;
    localparam int RANK_BITS  = 4;
    localparam int CFG_BITS   = 5;
    localparam int K_CNT_BITS = $clog2(K_MAX + 1);
    localparam int K_IDX_BITS = (K_MAX > 1) ? $clog2(K_MAX) : 1;

    localparam logic [CFG_BITS-1:0] K_RESET = CFG_BITS'(16);

    typedef struct packed {
        logic [DIST_BITS-1:0]  key;
        logic [INDEX_BITS-1:0] idx;
        logic [LABEL_BITS-1:0] lab;
        logic                  valid;
    } t_slot;

    localparam t_slot EMPTY_SLOT = '{key: '1, idx: '0, lab: '0, valid: 1'b0};

    // controller -> datapath
    typedef struct packed {
        logic                  insert;  // candidate request accepted
        logic                  emit;    // move list head into output register
        logic                  clear;   // empty the whole list
        logic [K_IDX_BITS-1:0] rank;    // rank of the entry being emitted
        logic                  last;    // entry being emitted is rank k-1
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;                 // output register can take a result
    } t_dp_status;

    // Clamp programmed k to 1..K_MAX.
    function automatic logic [K_CNT_BITS-1:0] eff_k(input logic [CFG_BITS-1:0] k);
        logic [K_CNT_BITS-1:0] r;
        if (k == '0) begin
            r = K_CNT_BITS'(1);
        end else if (int'(k) > K_MAX) begin
            r = K_CNT_BITS'(K_MAX);
        end else begin
            r = K_CNT_BITS'(k);
        end
        return r;
    endfunction

endpackage

@@ hdl/tkns_ctrl.sv @@
// Controller of the top-k selector: run/emit state machine and emission counter.
// Depends on tkns_pkg.
module tkns_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_last_candidate,
    input  logic [tkns_pkg::K_CNT_BITS-1:0] i_k_eff,
    input  tkns_pkg::t_dp_status         i_status,
    output tkns_pkg::t_dp_cmd            o_cmd,
    output logic                         o_in_stall
);
    import tkns_pkg::*;

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [K_IDX_BITS-1:0] r_count, n_count;
    logic [K_IDX_BITS-1:0] k_last;

    assign k_last = K_IDX_BITS'(i_k_eff - 1'b1);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        o_cmd      = '0;
        o_cmd.rank = r_count;
        o_cmd.last = (r_count >= k_last);
        o_in_stall = 1'b1;
        case (r_state)
            S_RUN: begin
                o_in_stall   = 1'b0;
                o_cmd.insert = i_in_valid;
                if (i_in_valid && i_last_candidate) begin
                    n_state = S_EMIT;
                    n_count = '0;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_count    = r_count + 1'b1;
                    if (r_count >= k_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_RUN;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

@@ hdl/tkns_datapath.sv @@
// Datapath of the top-k selector: sorted slot row with compare-and-shift insert,
// shift-out emission and the result register. Depends on tkns_pkg.
module tkns_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tkns_pkg::t_dp_cmd               i_cmd,
    input  logic [tkns_pkg::K_CNT_BITS-1:0] i_k_eff,
    input  logic [tkns_pkg::DIST_BITS-1:0]  i_distance,
    input  logic [tkns_pkg::INDEX_BITS-1:0] i_train_index,
    input  logic [tkns_pkg::LABEL_BITS-1:0] i_class_label,
    input  logic                            i_out_stall,
    output tkns_pkg::t_dp_status            o_status,
    output logic                            o_out_valid,
    output logic [tkns_pkg::RANK_BITS-1:0]  o_rank,
    output logic [tkns_pkg::DIST_BITS-1:0]  o_neighbour_distance,
    output logic [tkns_pkg::INDEX_BITS-1:0] o_neighbour_index,
    output logic [tkns_pkg::LABEL_BITS-1:0] o_neighbour_label,
    output logic                            o_entry_valid,
    output logic                            o_last_result
);
    import tkns_pkg::*;

    t_slot                 r_slots [K_MAX];
    t_slot                 n_slots [K_MAX];
    t_slot                 new_slot;
    logic [K_MAX-1:0]      lt;       // candidate strictly closer than slot
    logic [K_MAX-1:0]      ahead;    // candidate closer than some earlier slot
    logic                  enter;
    logic [K_IDX_BITS-1:0] k_last;

    t_slot                 r_out;
    logic                  r_out_valid;
    logic [RANK_BITS-1:0]  r_rank;
    logic                  r_last;

    assign k_last   = K_IDX_BITS'(i_k_eff - 1'b1);
    assign new_slot = '{key: i_distance, idx: i_train_index, lab: i_class_label,
                        valid: 1'b1};

    always_comb begin
        for (int j = 0; j < K_MAX; j++) begin
            lt[j] = (j < int'(i_k_eff)) && (i_distance < r_slots[j].key);
        end
        ahead[0] = 1'b0;
        for (int j = 1; j < K_MAX; j++) begin
            ahead[j] = ahead[j-1] | lt[j-1];
        end
    end

    assign enter = lt[k_last];

    always_comb begin
        for (int j = 0; j < K_MAX; j++) begin
            n_slots[j] = r_slots[j];
            if (i_cmd.clear) begin
                n_slots[j] = EMPTY_SLOT;
            end else if (i_cmd.emit) begin
                // shift toward the head; tail refills empty
                n_slots[j] = (j == K_MAX - 1) ? EMPTY_SLOT
                                              : r_slots[(j < K_MAX - 1) ? j + 1 : j];
            end else if (i_cmd.insert && enter) begin
                // only slots below k move; the rest stay until the clear
                if (lt[j]) begin
                    n_slots[j] = ahead[j] ? r_slots[(j > 0) ? j - 1 : 0] : new_slot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < K_MAX; j++) begin
                r_slots[j] <= EMPTY_SLOT;
            end
        end else begin
            for (int j = 0; j < K_MAX; j++) begin
                r_slots[j] <= n_slots[j];
            end
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out  <= r_slots[0];
            r_rank <= RANK_BITS'(i_cmd.rank);
            r_last <= i_cmd.last;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_rank               = r_rank;
    assign o_neighbour_distance = r_out.key;
    assign o_neighbour_index    = r_out.idx;
    assign o_neighbour_label    = r_out.lab;
    assign o_entry_valid        = r_out.valid;
    assign o_last_result        = r_last;

endmodule

@@ hdl/top_k_nearest_selector.sv @@
// Top level of the top-k nearest neighbor selector: APB register, controller
// and datapath. Depends on tkns_pkg, tkns_ctrl and tkns_datapath.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): while not stalled, one candidate
//    request per cycle (distance, training index, label, last flag). Non-last
//    requests yield no result and go back to back into the sorted slot row.
//  - A request with last_candidate set is inserted too; the block then stalls
//    its input and emits k results, rank 0 first, on the output channel
//    (o_out_valid / i_out_stall), one per cycle while the receiver takes them.
//    After the last request, the controller enters its emit state and the first
//    result is then loaded into the result register. The k results come from
//    the single shift-out path through the result register.
//  - Rank k-1 carries o_last_result. On that step the list is emptied and the
//    input reopens at once, even while that result still waits to be taken.
//  - Output stall freezes the result register and the emission counter.
//  - k_in_use sits at APB address 0 (reset 16; 0 acts as 1, above 16 as 16).
//    Write it only between queries.
//  - Reset (synchronous, active low) empties the list, drops any pending
//    result and restores k to 16.
module top_k_nearest_selector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [1:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // candidate requests
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [tkns_pkg::DIST_BITS-1:0]  i_distance,
    input  logic [tkns_pkg::INDEX_BITS-1:0] i_train_index,
    input  logic [tkns_pkg::LABEL_BITS-1:0] i_class_label,
    input  logic                            i_last_candidate,
    // neighbor results
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [tkns_pkg::RANK_BITS-1:0]  o_rank,
    output logic [tkns_pkg::DIST_BITS-1:0]  o_neighbour_distance,
    output logic [tkns_pkg::INDEX_BITS-1:0] o_neighbour_index,
    output logic [tkns_pkg::LABEL_BITS-1:0] o_neighbour_label,
    output logic                            o_entry_valid,
    output logic                            o_last_result
);
    import tkns_pkg::*;

    logic [CFG_BITS-1:0]   r_k_in_use;
    logic [K_CNT_BITS-1:0] k_eff;
    logic                  cfg_write;
    t_dp_cmd               dp_cmd;
    t_dp_status            dp_status;

    // Single register; every byte address of the window maps onto it.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[1:0] <= 2'd3);
    assign prdata    = 32'(r_k_in_use);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_in_use <= K_RESET;
        end else if (cfg_write) begin
            r_k_in_use <= pwdata[CFG_BITS-1:0];
        end
    end

    assign k_eff = eff_k(r_k_in_use);

    tkns_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_last_candidate (i_last_candidate),
        .i_k_eff          (k_eff),
        .i_status         (dp_status),
        .o_cmd            (dp_cmd),
        .o_in_stall       (o_in_stall)
    );

    tkns_datapath u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (dp_cmd),
        .i_k_eff              (k_eff),
        .i_distance           (i_distance),
        .i_train_index        (i_train_index),
        .i_class_label        (i_class_label),
        .i_out_stall          (i_out_stall),
        .o_status             (dp_status),
        .o_out_valid          (o_out_valid),
        .o_rank               (o_rank),
        .o_neighbour_distance (o_neighbour_distance),
        .o_neighbour_index    (o_neighbour_index),
        .o_neighbour_label    (o_neighbour_label),
        .o_entry_valid        (o_entry_valid),
        .o_last_result        (o_last_result)
    );

`ifndef ASSERT_OFF
    // A query end closes the input for the emission phase.
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_candidate) |=> o_in_stall)
        else $error("input not stalled after last candidate");

    // Within one emission, ranks follow one another without gaps.
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_result)
        |=> (o_out_valid && (o_rank == RANK_BITS'($past(o_rank) + 1'b1))))
        else $error("emitted rank sequence broken");

    // An emitted slot that is empty must carry the empty-slot payload.
    a_empty_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_entry_valid)
        |-> ((o_neighbour_distance == '1) && (o_neighbour_index == '0)
             && (o_neighbour_label == '0)))
        else $error("empty slot emitted with stale payload");
`endif

endmodule
